// ----- src/assert_macros.svh -----
// Concurrent assertion macros used by the top RTL file of the mode sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Implication or sequence property checked on every rising clock edge out of reset.
`define ASSERT_PROP(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Boolean condition that must never be true out of reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

// ----- src/rcms_pkg.sv -----
// Types, codes and reset constants of the combat mode sequencer.
`default_nettype none

package rcms_pkg;

  typedef enum logic [2:0] {
    MODE_WAIT    = 3'd0,
    MODE_SEARCH  = 3'd1,
    MODE_CHASE   = 3'd2,
    MODE_ATTACK  = 3'd3,
    MODE_REVERSE = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    MOT_STOP  = 3'd0,
    MOT_FWD   = 3'd1,
    MOT_REV   = 3'd2,
    MOT_RIGHT = 3'd3,
    MOT_LEFT  = 3'd4,
    MOT_NONE  = 3'd5
  } motion_e;

  typedef enum logic [2:0] {
    CFG_WAIT_MS       = 3'd0,
    CFG_SEARCH_FWD_MS = 3'd1,
    CFG_SEARCH_TURN_MS = 3'd2,
    CFG_REPOS_TIMES   = 3'd3,
    CFG_DETECT_DIST   = 3'd4,
    CFG_ATTACK_DIST   = 3'd5,
    CFG_MAX_MISSES    = 3'd6,
    CFG_SPEED_SET     = 3'd7
  } cfg_idx_e;

  // Byte lanes of the speed register.
  localparam int unsigned SpdSearch = 0;
  localparam int unsigned SpdTurn   = 1;
  localparam int unsigned SpdChase  = 2;
  localparam int unsigned SpdAttack = 3;
  localparam int unsigned SpdRepos  = 4;
  localparam int unsigned NumSpeeds = 5;

  localparam int unsigned CfgDataW = 40;
  localparam int unsigned CfgIdxW  = 3;

  localparam logic [15:0] WaitMsRst     = 16'd5000;
  localparam logic [15:0] SearchFwdRst  = 16'd500;
  localparam logic [15:0] SearchTurnRst = 16'd500;
  localparam logic [15:0] BackMsRst     = 16'd0;
  localparam logic [15:0] TurnMsRst     = 16'd0;
  localparam logic [15:0] DetectRst     = 16'd400;
  localparam logic [15:0] AttackRst     = 16'd100;
  localparam logic [7:0]  MaxMissesRst  = 8'd3;

  localparam int unsigned InTdataW  = 88;
  localparam int unsigned OutTdataW = 16;

  typedef struct packed {
    logic [15:0] wait_ms;
    logic [15:0] search_fwd_ms;
    logic [15:0] search_turn_ms;
    logic [15:0] back_ms;
    logic [15:0] turn_ms;
    logic [15:0] detect_dist;
    logic [15:0] attack_dist;
    logic [7:0]  max_misses;
    logic [NumSpeeds-1:0][7:0] speed;
  } cfg_t;

  typedef struct packed {
    mode_e       mode;
    logic [31:0] entry_time;
    logic [7:0]  miss_count;
    logic        sweep_cw;
    logic        edge_left;
    logic        edge_right;
  } state_t;

  typedef struct packed {
    logic [15:0] dist_left;
    logic [15:0] dist_front;
    logic [15:0] dist_right;
    logic        line_left;
    logic        line_right;
    logic [31:0] now_ms;
  } item_t;

  typedef struct packed {
    motion_e    motion;
    logic [7:0] speed;
    mode_e      mode;
  } result_t;

endpackage

`default_nettype wire

// ----- src/rcms_step.sv -----
// Combinational update of the mode machine for one sensor item.
`default_nettype none

module rcms_step
  import rcms_pkg::*;
(
  input  cfg_t    cfg_i,
  input  state_t  state_i,
  input  item_t   item_i,
  output state_t  state_o,
  output result_t result_o
);

  logic [31:0] elapsed;
  logic [15:0] min_lf;
  logic [15:0] min_dist;
  logic        target_seen;
  logic        edge_seen;
  logic [16:0] search_end;
  logic [16:0] repos_end;
  logic        in_search_end;
  logic        in_repos_end;
  logic [7:0]  miss_inc;
  motion_e     sweep_dir;
  state_t      nxt;
  motion_e     motion;
  logic [7:0]  speed;

  assign elapsed     = item_i.now_ms - state_i.entry_time;
  assign min_lf      = (item_i.dist_front < item_i.dist_left) ? item_i.dist_front
                                                              : item_i.dist_left;
  assign min_dist    = (item_i.dist_right < min_lf) ? item_i.dist_right : min_lf;
  assign target_seen = min_dist < cfg_i.detect_dist;
  assign edge_seen   = item_i.line_left | item_i.line_right;

  // Window ends are summed one bit wider so that they never wrap.
  assign search_end    = {1'b0, cfg_i.search_fwd_ms} + {1'b0, cfg_i.search_turn_ms};
  assign repos_end     = {1'b0, cfg_i.back_ms} + {1'b0, cfg_i.turn_ms};
  assign in_search_end = {1'b0, elapsed} < {16'd0, search_end};
  assign in_repos_end  = {1'b0, elapsed} < {16'd0, repos_end};

  assign miss_inc  = (state_i.miss_count == 8'hFF) ? state_i.miss_count
                                                   : state_i.miss_count + 8'd1;
  assign sweep_dir = state_i.sweep_cw ? MOT_RIGHT : MOT_LEFT;

  always_comb begin
    nxt    = state_i;
    motion = MOT_NONE;
    speed  = 8'd0;

    if (edge_seen && ((state_i.mode == MODE_SEARCH) || (state_i.mode == MODE_CHASE) ||
                      (state_i.mode == MODE_ATTACK))) begin
      nxt.edge_left  = item_i.line_left;
      nxt.edge_right = item_i.line_right;
      motion         = MOT_REV;
      speed          = cfg_i.speed[SpdRepos];
      nxt.mode       = MODE_REVERSE;
      nxt.entry_time = item_i.now_ms;
    end else begin
      case (state_i.mode)
        MODE_WAIT: begin
          motion = MOT_STOP;
          if (elapsed >= {16'd0, cfg_i.wait_ms}) begin
            nxt.mode       = MODE_SEARCH;
            nxt.entry_time = item_i.now_ms;
          end
        end
        MODE_SEARCH: begin
          if (target_seen) begin
            nxt.miss_count = 8'd0;
            nxt.mode       = MODE_CHASE;
            nxt.entry_time = item_i.now_ms;
          end else if (elapsed < {16'd0, cfg_i.search_fwd_ms}) begin
            motion = MOT_FWD;
            speed  = cfg_i.speed[SpdSearch];
          end else if (in_search_end) begin
            motion = sweep_dir;
            speed  = cfg_i.speed[SpdTurn];
          end else begin
            nxt.sweep_cw   = ~state_i.sweep_cw;
            nxt.entry_time = item_i.now_ms;
          end
        end
        MODE_CHASE: begin
          if (!target_seen) begin
            nxt.miss_count = miss_inc;
            if (miss_inc >= cfg_i.max_misses) begin
              nxt.mode       = MODE_SEARCH;
              nxt.entry_time = item_i.now_ms;
            end
          end else begin
            nxt.miss_count = 8'd0;
            if (item_i.dist_front <= cfg_i.attack_dist) begin
              nxt.mode       = MODE_ATTACK;
              nxt.entry_time = item_i.now_ms;
            end else if ((item_i.dist_left < item_i.dist_front) &&
                         (item_i.dist_left <= item_i.dist_right)) begin
              motion = MOT_LEFT;
              speed  = cfg_i.speed[SpdChase];
            end else if (item_i.dist_right < item_i.dist_front) begin
              motion = MOT_RIGHT;
              speed  = cfg_i.speed[SpdChase];
            end else begin
              motion = MOT_FWD;
              speed  = cfg_i.speed[SpdChase];
            end
          end
        end
        MODE_ATTACK: begin
          if (item_i.dist_front >= cfg_i.attack_dist) begin
            nxt.mode       = MODE_SEARCH;
            nxt.entry_time = item_i.now_ms;
          end else begin
            motion = MOT_FWD;
            speed  = cfg_i.speed[SpdAttack];
          end
        end
        MODE_REVERSE: begin
          if (elapsed < {16'd0, cfg_i.back_ms}) begin
            motion = MOT_REV;
            speed  = cfg_i.speed[SpdRepos];
          end else if (in_repos_end) begin
            speed = cfg_i.speed[SpdTurn];
            // Turn away from the side where the border was seen.
            if (state_i.edge_left && !state_i.edge_right) begin
              motion = MOT_RIGHT;
            end else if (state_i.edge_right && !state_i.edge_left) begin
              motion = MOT_LEFT;
            end else begin
              motion = sweep_dir;
            end
          end else begin
            nxt.mode       = MODE_SEARCH;
            nxt.entry_time = item_i.now_ms;
          end
        end
        default: begin
          nxt.mode       = MODE_WAIT;
          nxt.entry_time = item_i.now_ms;
        end
      endcase
    end
  end

  assign state_o         = nxt;
  assign result_o.motion = motion;
  assign result_o.speed  = speed;
  assign result_o.mode   = nxt.mode;

endmodule

`default_nettype wire

// ----- src/robot_combat_mode_sequencer.sv -----
// A result passes the input register, then the result register, before it is offered.
// Throughput: one sensor item per cycle while the result side does not stall; the mode
// update is a single combinational pass.
// Backpressure on the result side stalls both stages; the input side keeps taking items
// while the input register is empty or moving forward.
// Reset clears the mode state (wait mode, clockwise sweep) and loads the register defaults.
`default_nettype none
`include "assert_macros.svh"

module robot_combat_mode_sequencer
  import rcms_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,

  // Configuration write port, no read-back.
  input  wire logic                 cfg_we_i,
  input  wire logic [CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [CfgDataW-1:0]  cfg_data_i,

  // Sensor items. tdata from bit 0 up: dist_left[15:0], dist_front[15:0],
  // dist_right[15:0], line_left, line_right, now_ms[31:0], zero padding.
  input  wire logic                 s_axis_tvalid,
  output      logic                 s_axis_tready,
  input  wire logic [InTdataW-1:0]  s_axis_tdata,

  // Motor commands. tdata from bit 0 up: motion[2:0], speed[7:0], mode[2:0],
  // zero padding.
  output      logic                 m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output      logic [OutTdataW-1:0] m_axis_tdata
);

  // ---------------------------------------------------------------------------
  // Configuration registers. The repositioning register splits into backing
  // and turning times, and the speed register into five byte-wide speeds.
  // ---------------------------------------------------------------------------
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wait_ms        <= WaitMsRst;
      cfg_q.search_fwd_ms  <= SearchFwdRst;
      cfg_q.search_turn_ms <= SearchTurnRst;
      cfg_q.back_ms        <= BackMsRst;
      cfg_q.turn_ms        <= TurnMsRst;
      cfg_q.detect_dist    <= DetectRst;
      cfg_q.attack_dist    <= AttackRst;
      cfg_q.max_misses     <= MaxMissesRst;
      cfg_q.speed          <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_WAIT_MS:        cfg_q.wait_ms        <= cfg_data_i[15:0];
        CFG_SEARCH_FWD_MS:  cfg_q.search_fwd_ms  <= cfg_data_i[15:0];
        CFG_SEARCH_TURN_MS: cfg_q.search_turn_ms <= cfg_data_i[15:0];
        CFG_REPOS_TIMES: begin
          cfg_q.back_ms <= cfg_data_i[15:0];
          cfg_q.turn_ms <= cfg_data_i[31:16];
        end
        CFG_DETECT_DIST:    cfg_q.detect_dist    <= cfg_data_i[15:0];
        CFG_ATTACK_DIST:    cfg_q.attack_dist    <= cfg_data_i[15:0];
        CFG_MAX_MISSES:     cfg_q.max_misses     <= cfg_data_i[7:0];
        CFG_SPEED_SET:      cfg_q.speed          <= cfg_data_i[NumSpeeds*8-1:0];
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake control. The input register moves forward whenever the result
  // register is empty or its result is taken in the same cycle, so while results
  // are taken a new item follows every cycle without a bubble.
  // ---------------------------------------------------------------------------
  logic    in_valid_q;
  item_t   in_item_q;
  logic    out_valid_q;
  result_t out_res_q;
  logic    advance;
  logic    fire;
  logic    in_xfer;

  assign advance       = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  // Unpack the sensor fields; the padding bits above now_ms are ignored.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_item_q.dist_left  <= s_axis_tdata[15:0];
      in_item_q.dist_front <= s_axis_tdata[31:16];
      in_item_q.dist_right <= s_axis_tdata[47:32];
      in_item_q.line_left  <= s_axis_tdata[48];
      in_item_q.line_right <= s_axis_tdata[49];
      in_item_q.now_ms     <= s_axis_tdata[81:50];
    end
  end

  // ---------------------------------------------------------------------------
  // Mode state and the single-pass update. The state register is written in
  // the same cycle as the result register, so the next item already sees the
  // updated mode, entry time, miss count and edge sides.
  // ---------------------------------------------------------------------------
  state_t  state_q;
  state_t  state_d;
  result_t res_d;

  rcms_step u_step (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .item_i   (in_item_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode       <= MODE_WAIT;
      state_q.entry_time <= '0;
      state_q.miss_count <= '0;
      state_q.sweep_cw   <= 1'b1;
      state_q.edge_left  <= 1'b0;
      state_q.edge_right <= 1'b0;
    end else if (fire) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_res_q.mode, out_res_q.speed, out_res_q.motion};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------

  // A stop or a missing command never carries a speed.
  `ASSERT_NEVER(a_idle_speed_zero, clk_i, rst_ni,
                out_valid_q && ((out_res_q.motion == MOT_STOP) ||
                (out_res_q.motion == MOT_NONE)) && (out_res_q.speed != 8'd0))

  // Backing up is only commanded while the machine is in reverse mode.
  `ASSERT_NEVER(a_rev_in_reverse, clk_i, rst_ni,
                out_valid_q && (out_res_q.motion == MOT_REV) &&
                (out_res_q.mode != MODE_REVERSE))

  // A stop comes only from wait mode, possibly just leaving it for search.
  `ASSERT_NEVER(a_stop_from_wait, clk_i, rst_ni,
                out_valid_q && (out_res_q.motion == MOT_STOP) &&
                (out_res_q.mode != MODE_WAIT) && (out_res_q.mode != MODE_SEARCH))

  // An item that moves forward always lands in the result register.
  `ASSERT_PROP(a_fire_loads_out, clk_i, rst_ni, fire |=> out_valid_q)

  // A stalled item stays in the input register.
  `ASSERT_PROP(a_stall_holds_in, clk_i, rst_ni, (in_valid_q && !advance) |=> in_valid_q)

endmodule

`default_nettype wire
